/* sv/sensor_raw_compensation_macros.svh */
// Assertion macros for the sensor compensation checker.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef SENSOR_RAW_COMPENSATION_MACROS_SVH
`define SENSOR_RAW_COMPENSATION_MACROS_SVH

// Same-cycle implication.
`define SRC_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sensor compensation check failed");

// Next-cycle implication.
`define SRC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sensor compensation check failed");

`endif

/* sv/src_pkg.sv */
// Shared types and constants for the sensor raw compensation pipeline.
// No dependencies.
package src_pkg;

   // Pipeline depths
   localparam int TF_LAT    = 4;
   localparam int DIV_W     = 32;
   localparam int DIV_LAT   = DIV_W;
   localparam int HUM_LAT   = 11;
   localparam int PRESS_LAT = 12 + DIV_LAT;
   localparam int TOTAL_LAT = TF_LAT + PRESS_LAT;

   localparam logic [31:0] HUM_LIMIT = 32'd419430400;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_TEMP       = 3'd0,
      CSR_PRESS_LOW  = 3'd1,
      CSR_PRESS_HIGH = 3'd2,
      CSR_MIXED      = 3'd3,
      CSR_HUM        = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
      logic [15:0] raw_humidity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_pa;
      logic               pressure_valid;
      logic [16:0]        humidity_q10;
   } rsp_type;

   // Coefficients, each extended to a 32-bit word
   typedef struct packed {
      logic [31:0] t1, t2, t3;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
   } coef_type;

endpackage

/* sv/sensor_raw_compensation.sv */
// Raw sample compensation for a temperature / pressure / humidity sensor.
// One beat per clock in and out unless a result waits on rsp_ready. Every beat
// passes the fine temperature, pressure arithmetic and pipelined divider stages
// (one quotient bit per stage). The whole pipeline holds while a result waits on
// rsp_ready. The user must write coefficients through csr_* only while no beat is
// in flight; the block does not enforce this. Coefficients reset to zero.
// Depends on src_pkg, src_tfine, src_hum, src_press, src_div.
module sensor_raw_compensation import src_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [47:0] temp_ff, mixed_ff;
   logic [63:0] plow_ff, phigh_ff;
   logic [39:0] hum_ff;
   coef_type    coef;
   logic        adv;
   logic        vld_ff [TOTAL_LAT];
   logic [31:0] tf;
   logic [19:0] raw_p;
   logic [15:0] raw_h;
   logic [16:0] hum;
   logic [31:0] press;
   logic        press_ok;
   logic [31:0] tc_in;
   logic [31:0] tc_ff  [PRESS_LAT];
   logic [16:0] hd_ff  [PRESS_LAT-HUM_LAT];

   // Coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff  <= '0;
         plow_ff  <= '0;
         phigh_ff <= '0;
         mixed_ff <= '0;
         hum_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEMP:       temp_ff  <= csr_wdata[47:0];
            CSR_PRESS_LOW:  plow_ff  <= csr_wdata;
            CSR_PRESS_HIGH: phigh_ff <= csr_wdata;
            CSR_MIXED:      mixed_ff <= csr_wdata[47:0];
            CSR_HUM:        hum_ff   <= csr_wdata[39:0];
            default: ;
         endcase
      end
   end

   // Unpack and extend coefficients
   always_comb begin
      coef.t1 = 32'(temp_ff[15:0]);
      coef.t2 = 32'($signed(temp_ff[31:16]));
      coef.t3 = 32'($signed(temp_ff[47:32]));
      coef.p1 = 32'(plow_ff[15:0]);
      coef.p2 = 32'($signed(plow_ff[31:16]));
      coef.p3 = 32'($signed(plow_ff[47:32]));
      coef.p4 = 32'($signed(plow_ff[63:48]));
      coef.p5 = 32'($signed(phigh_ff[15:0]));
      coef.p6 = 32'($signed(phigh_ff[31:16]));
      coef.p7 = 32'($signed(phigh_ff[47:32]));
      coef.p8 = 32'($signed(phigh_ff[63:48]));
      coef.p9 = 32'($signed(mixed_ff[15:0]));
      coef.h1 = 32'(mixed_ff[23:16]);
      coef.h2 = 32'($signed(mixed_ff[39:24]));
      coef.h3 = 32'(mixed_ff[47:40]);
      coef.h4 = 32'($signed(hum_ff[15:0]));
      coef.h5 = 32'($signed(hum_ff[31:16]));
      coef.h6 = 32'($signed(hum_ff[39:32]));
   end

   // Global advance: move unless the output beat is stuck
   assign adv       = ~vld_ff[TOTAL_LAT-1] | rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_LAT; i++)
            vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < TOTAL_LAT; i++)
            vld_ff[i] <= vld_ff[i-1];
      end
   end

   src_tfine u_tfine (
      .clock (clock),
      .adv   (adv),
      .coef  (coef),
      .req   (req_data),
      .tf    (tf),
      .raw_p (raw_p),
      .raw_h (raw_h)
   );

   src_hum u_hum (
      .clock (clock),
      .adv   (adv),
      .coef  (coef),
      .tf    (tf),
      .raw_h (raw_h),
      .hum   (hum)
   );

   src_press u_press (
      .clock    (clock),
      .adv      (adv),
      .coef     (coef),
      .tf       (tf),
      .raw_p    (raw_p),
      .press    (press),
      .press_ok (press_ok)
   );

   // Temperature output, then delay lines to line up with pressure
   assign tc_in = 32'($signed(tf * 32'd5 + 32'd128) >>> 8);

   always_ff @(posedge clock) begin
      if (adv) begin
         tc_ff[0] <= tc_in;
         for (int i = 1; i < PRESS_LAT; i++)
            tc_ff[i] <= tc_ff[i-1];
         hd_ff[0] <= hum;
         for (int i = 1; i < PRESS_LAT - HUM_LAT; i++)
            hd_ff[i] <= hd_ff[i-1];
      end
   end

   assign rsp_valid                  = vld_ff[TOTAL_LAT-1];
   assign rsp_data.temperature_centi = $signed(tc_ff[PRESS_LAT-1]);
   assign rsp_data.pressure_pa       = press;
   assign rsp_data.pressure_valid    = press_ok;
   assign rsp_data.humidity_q10      = hd_ff[PRESS_LAT-HUM_LAT-1];

endmodule

/* sv/src_tfine.sv */
// Fine temperature stages: four register stages from raw temperature to t_fine.
// Depends on src_pkg.
module src_tfine import src_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  coef_type    coef,
   input  req_type     req,
   output logic [31:0] tf,
   output logic [19:0] raw_p,
   output logic [15:0] raw_h
);

   logic [31:0] a_in, b_in, a_ff, b_ff;
   logic [31:0] m1_in, bb_in, m1_ff, bb_ff;
   logic [31:0] v1_in, m2_in, v1_ff, m2_ff;
   logic [31:0] tf_in, tf_ff;
   logic [19:0] rp_ff [TF_LAT];
   logic [15:0] rh_ff [TF_LAT];

   // Stage math
   always_comb begin
      a_in  = 32'(req.raw_temperature >> 3) - (coef.t1 << 1);
      b_in  = 32'(req.raw_temperature >> 4) - coef.t1;
      m1_in = a_ff * coef.t2;
      bb_in = b_ff * b_ff;
      v1_in = 32'($signed(m1_ff) >>> 11);
      m2_in = 32'($signed(bb_ff) >>> 12) * coef.t3;
      tf_in = v1_ff + 32'($signed(m2_ff) >>> 14);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         m1_ff <= m1_in;
         bb_ff <= bb_in;
         v1_ff <= v1_in;
         m2_ff <= m2_in;
         tf_ff <= tf_in;
         rp_ff[0] <= req.raw_pressure;
         rh_ff[0] <= req.raw_humidity;
         for (int i = 1; i < TF_LAT; i++) begin
            rp_ff[i] <= rp_ff[i-1];
            rh_ff[i] <= rh_ff[i-1];
         end
      end
   end

   assign tf    = tf_ff;
   assign raw_p = rp_ff[TF_LAT-1];
   assign raw_h = rh_ff[TF_LAT-1];

endmodule

/* sv/src_hum.sv */
// Humidity compensation stages from t_fine and raw humidity, clamped output.
// Depends on src_pkg.
module src_hum import src_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  coef_type    coef,
   input  logic [31:0] tf,
   input  logic [15:0] raw_h,
   output logic [16:0] hum
);

   logic [31:0] x1_ff, x1_in;
   logic [15:0] rh1_ff;
   logic [31:0] mh5_ff, mh6_ff, mh3_ff, pre_ff;
   logic [31:0] mh5_in, mh6_in, mh3_in, pre_in;
   logic [31:0] a3_ff, c1_ff, c2_ff, a3_in, c1_in, c2_in;
   logic [31:0] a4_ff, b4_ff, b4_in;
   logic [31:0] a5_ff, b5_ff, b5_in;
   logic [31:0] a6_ff, b6_ff, b6_in;
   logic [31:0] x7_ff, x7_in;
   logic [31:0] x8_ff, s8_ff, s8_in;
   logic [31:0] x9_ff, ss9_ff, ss9_in;
   logic [31:0] x10_ff, u10_ff, u10_in;
   logic [31:0] y;
   logic [31:0] yc;
   logic [16:0] h_in, h_ff;

   always_comb begin
      x1_in  = tf - 32'd76800;
      mh5_in = coef.h5 * x1_ff;
      mh6_in = x1_ff * coef.h6;
      mh3_in = x1_ff * coef.h3;
      pre_in = (32'(rh1_ff) << 14) - (coef.h4 << 20);
      a3_in  = 32'($signed(pre_ff - mh5_ff + 32'd16384) >>> 15);
      c1_in  = 32'($signed(mh6_ff) >>> 10);
      c2_in  = 32'($signed(mh3_ff) >>> 11) + 32'd32768;
      b4_in  = c1_ff * c2_ff;
      b5_in  = (32'($signed(b4_ff) >>> 10) + 32'd2097152) * coef.h2;
      b6_in  = 32'($signed(b5_ff + 32'd8192) >>> 14);
      x7_in  = a6_ff * b6_ff;
      s8_in  = 32'($signed(x7_ff) >>> 15);
      ss9_in = s8_ff * s8_ff;
      u10_in = 32'($signed(ss9_ff) >>> 7) * coef.h1;
      // final subtract and clamp to 0..HUM_LIMIT
      y  = x10_ff - 32'($signed(u10_ff) >>> 4);
      if (y[31])
         yc = '0;
      else if (y > HUM_LIMIT)
         yc = HUM_LIMIT;
      else
         yc = y;
      h_in = yc[28:12];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff  <= x1_in;
         rh1_ff <= raw_h;
         mh5_ff <= mh5_in;
         mh6_ff <= mh6_in;
         mh3_ff <= mh3_in;
         pre_ff <= pre_in;
         a3_ff  <= a3_in;
         c1_ff  <= c1_in;
         c2_ff  <= c2_in;
         a4_ff  <= a3_ff;
         b4_ff  <= b4_in;
         a5_ff  <= a4_ff;
         b5_ff  <= b5_in;
         a6_ff  <= a5_ff;
         b6_ff  <= b6_in;
         x7_ff  <= x7_in;
         x8_ff  <= x7_ff;
         s8_ff  <= s8_in;
         x9_ff  <= x8_ff;
         ss9_ff <= ss9_in;
         x10_ff <= x9_ff;
         u10_ff <= u10_in;
         h_ff   <= h_in;
      end
   end

   assign hum = h_ff;

endmodule

/* sv/src_div.sv */
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// Depends on src_pkg.
module src_div import src_pkg::*; (
   input  logic             clock,
   input  logic             adv,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic [DIV_W-1:0] quo
);

   logic [DIV_W-1:0] rem_ff [DIV_LAT];
   logic [DIV_W-1:0] num_ff [DIV_LAT];
   logic [DIV_W-1:0] den_ff [DIV_LAT];
   logic [DIV_W-1:0] quo_ff [DIV_LAT];

   for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
      logic [DIV_W-1:0] rem_prev, num_prev, den_prev, quo_prev;
      logic [DIV_W:0]   trial;
      logic [DIV_W:0]   diff;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      // shift in next dividend bit, subtract when it fits
      assign trial = {rem_prev, num_prev[DIV_W-1]};
      assign diff  = trial - {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
            quo_ff[k] <= {quo_prev[DIV_W-2:0], ~diff[DIV_W]};
            num_ff[k] <= num_prev << 1;
            den_ff[k] <= den_prev;
         end
      end
   end

   assign quo = quo_ff[DIV_LAT-1];

endmodule

/* sv/src_press.sv */
// Pressure compensation: divisor and dividend stages, divider, correction stages.
// Depends on src_pkg and src_div.
module src_press import src_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  coef_type    coef,
   input  logic [31:0] tf,
   input  logic [19:0] raw_p,
   output logic [31:0] press,
   output logic        press_ok
);

   logic [31:0] v1_in, q_in, v1_ff, q_ff;
   logic [19:0] rp_ff [5];
   logic [31:0] qq_ff, m5_ff, m2_ff, qq_in, m5_in, m2_in;
   logic [31:0] m6_ff, m3_ff, m5b_ff, m2b_ff, m6_in, m3_in;
   logic [31:0] v2a_ff, v1a_ff, v2a_in, v1a_in;
   logic [31:0] w_ff, v2b_ff, w_in;
   logic [31:0] d6_ff, num_ff, d6_in, num_in;
   logic [31:0] pn_ff, d7_ff, pn_in;
   logic [31:0] dnum_ff, dden_ff, dnum_in;
   logic        dbl_ff, zero_ff;
   logic        dbl_dly_ff  [DIV_LAT];
   logic        zero_dly_ff [DIV_LAT];
   logic [31:0] quo;
   logic [31:0] p9_in, p9_ff, p10_ff, p11_ff;
   logic        ok9_ff, ok10_ff, ok11_ff;
   logic [31:0] aa_ff, m8_ff, aa_in, m8_in;
   logic [31:0] m9_ff, m8b_ff, m9_in;
   logic [31:0] corr;
   logic [31:0] out_in, out_ff;
   logic        ok_ff;

   // Divisor and dividend ahead of the divider
   always_comb begin
      v1_in   = 32'($signed(tf) >>> 1) - 32'd64000;
      q_in    = 32'($signed(v1_in) >>> 2);
      qq_in   = q_ff * q_ff;
      m5_in   = v1_ff * coef.p5;
      m2_in   = coef.p2 * v1_ff;
      m6_in   = 32'($signed(qq_ff) >>> 11) * coef.p6;
      m3_in   = coef.p3 * 32'($signed(qq_ff) >>> 13);
      v2a_in  = 32'($signed(m6_ff + (m5b_ff << 1)) >>> 2) + (coef.p4 << 16);
      v1a_in  = 32'($signed(32'($signed(m3_ff) >>> 3) + 32'($signed(m2b_ff) >>> 1)) >>> 18);
      w_in    = (32'd32768 + v1a_ff) * coef.p1;
      d6_in   = 32'($signed(w_ff) >>> 15);
      num_in  = (32'd1048576 - 32'(rp_ff[4])) - 32'($signed(v2b_ff) >>> 12);
      pn_in   = num_ff * 32'd3125;
      dnum_in = pn_ff[31] ? pn_ff : (pn_ff << 1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v1_ff   <= v1_in;
         q_ff    <= q_in;
         rp_ff[0] <= raw_p;
         for (int i = 1; i < 5; i++)
            rp_ff[i] <= rp_ff[i-1];
         qq_ff   <= qq_in;
         m5_ff   <= m5_in;
         m2_ff   <= m2_in;
         m6_ff   <= m6_in;
         m3_ff   <= m3_in;
         m5b_ff  <= m5_ff;
         m2b_ff  <= m2_ff;
         v2a_ff  <= v2a_in;
         v1a_ff  <= v1a_in;
         w_ff    <= w_in;
         v2b_ff  <= v2a_ff;
         d6_ff   <= d6_in;
         num_ff  <= num_in;
         pn_ff   <= pn_in;
         d7_ff   <= d6_ff;
         dnum_ff <= dnum_in;
         dden_ff <= d7_ff;
         dbl_ff  <= pn_ff[31];
         zero_ff <= (d7_ff == '0);
      end
   end

   src_div u_div (
      .clock (clock),
      .adv   (adv),
      .num   (dnum_ff),
      .den   (dden_ff),
      .quo   (quo)
   );

   // Side flags ride along the divider
   always_ff @(posedge clock) begin
      if (adv) begin
         dbl_dly_ff[0]  <= dbl_ff;
         zero_dly_ff[0] <= zero_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            dbl_dly_ff[i]  <= dbl_dly_ff[i-1];
            zero_dly_ff[i] <= zero_dly_ff[i-1];
         end
      end
   end

   // Correction after the divide
   always_comb begin
      p9_in = dbl_dly_ff[DIV_LAT-1] ? (quo << 1) : quo;
      aa_in = (p9_ff >> 3) * (p9_ff >> 3);
      m8_in = (p9_ff >> 2) * coef.p8;
      m9_in = coef.p9 * (aa_ff >> 13);
      corr  = 32'($signed(m9_ff) >>> 12) + 32'($signed(m8b_ff) >>> 13) + coef.p7;
      out_in = ok11_ff ? (p11_ff + 32'($signed(corr) >>> 4)) : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p9_ff   <= p9_in;
         ok9_ff  <= ~zero_dly_ff[DIV_LAT-1];
         aa_ff   <= aa_in;
         m8_ff   <= m8_in;
         p10_ff  <= p9_ff;
         ok10_ff <= ok9_ff;
         m9_ff   <= m9_in;
         m8b_ff  <= m8_ff;
         p11_ff  <= p10_ff;
         ok11_ff <= ok10_ff;
         out_ff  <= out_in;
         ok_ff   <= ok11_ff;
      end
   end

   assign press    = out_ff;
   assign press_ok = ok_ff;

endmodule

/* sv/src_chk.sv */
// Port-level checker for the sensor compensation block, bound to the top level.
// Depends on src_pkg and sensor_raw_compensation_macros.svh.
`include "sensor_raw_compensation_macros.svh"

module src_chk import src_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Zero divisor must give zero pressure
   `SRC_ASSERT_IMPL(a_zero_press, rsp_valid && !rsp_data.pressure_valid, rsp_data.pressure_pa == '0)

   // Humidity stays clamped
   `SRC_ASSERT_IMPL(a_hum_range, rsp_valid, rsp_data.humidity_q10 <= 17'd102400)

   // Input only stalls when the output beat is stuck
   `SRC_ASSERT_IMPL(a_ready_rule, 1'b1, req_ready == (!rsp_valid || rsp_ready))

   // A stalled result beat holds
   `SRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind sensor_raw_compensation src_chk u_src_chk (.*);

/* tb/tb_sensor_raw_compensation.sv */
// Testbench for sensor_raw_compensation: random and directed sample sets
// checked against a bit-exact compensation predictor. Depends on src_pkg.
`timescale 1ns / 100ps

module tb_sensor_raw_compensation;
   import src_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 2 * TOTAL_LAT + 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // Coefficient copies
   logic [47:0] temp_coef;
   logic [63:0] press_lo_coef, press_hi_coef;
   logic [47:0] mixed_coef;
   logic [39:0] hum_coef;

   rsp_type expected_q[$];
   int error_count = 0;
   int beats_sent = 0, beats_checked = 0;
   int send_idle_pct = 0, recv_stall_pct = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   sensor_raw_compensation dut (.*);

   function automatic logic [31:0] asr32(logic [31:0] x, int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // Bit-exact compensation of one sample set
   function automatic rsp_type compensate(req_type s);
      rsp_type r;
      logic [31:0] t1, t2, t3, a, b, v1, v2, q, p, tf, x, s2, hh;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      t1 = {16'd0, temp_coef[15:0]};
      t2 = sx16(temp_coef[31:16]);
      t3 = sx16(temp_coef[47:32]);
      a = {15'd0, s.raw_temperature[19:3]} - (t1 << 1);
      v1 = asr32(a * t2, 11);
      b = {16'd0, s.raw_temperature[19:4]} - t1;
      v2 = asr32(asr32(b * b, 12) * t3, 14);
      tf = v1 + v2;
      r.temperature_centi = $signed(asr32(tf * 32'd5 + 32'd128, 8));
      // pressure
      p1 = {16'd0, press_lo_coef[15:0]};
      p2 = sx16(press_lo_coef[31:16]);
      p3 = sx16(press_lo_coef[47:32]);
      p4 = sx16(press_lo_coef[63:48]);
      p5 = sx16(press_hi_coef[15:0]);
      p6 = sx16(press_hi_coef[31:16]);
      p7 = sx16(press_hi_coef[47:32]);
      p8 = sx16(press_hi_coef[63:48]);
      p9 = sx16(mixed_coef[15:0]);
      v1 = asr32(tf, 1) - 32'd64000;
      q = asr32(v1, 2);
      v2 = asr32(q * q, 11) * p6;
      v2 = v2 + ((v1 * p5) << 1);
      v2 = asr32(v2, 2) + (p4 << 16);
      v1 = asr32(asr32(p3 * asr32(q * q, 13), 3) + asr32(p2 * v1, 1), 18);
      v1 = asr32((32'd32768 + v1) * p1, 15);
      if (v1 == 32'd0) begin
         r.pressure_pa = '0;
         r.pressure_valid = 1'b0;
      end else begin
         p = ((32'd1048576 - {12'd0, s.raw_pressure}) - asr32(v2, 12)) * 32'd3125;
         if (p < 32'h8000_0000) p = (p << 1) / v1;
         else p = (p / v1) * 32'd2;
         v1 = asr32(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
         v2 = asr32((p >> 2) * p8, 13);
         r.pressure_pa = p + asr32(v1 + v2 + p7, 4);
         r.pressure_valid = 1'b1;
      end
      // humidity
      h1 = {24'd0, mixed_coef[23:16]};
      h2 = sx16(mixed_coef[39:24]);
      h3 = {24'd0, mixed_coef[47:40]};
      h4 = sx16(hum_coef[15:0]);
      h5 = sx16(hum_coef[31:16]);
      h6 = {{24{hum_coef[39]}}, hum_coef[39:32]};
      x = tf - 32'd76800;
      a = asr32(({16'd0, s.raw_humidity} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
      b = asr32(x * h6, 10) * (asr32(x * h3, 11) + 32'd32768);
      b = asr32(b, 10) + 32'd2097152;
      b = asr32(b * h2 + 32'd8192, 14);
      hh = a * b;
      s2 = asr32(hh, 15);
      hh = hh - asr32(asr32(s2 * s2, 7) * h1, 4);
      if (hh[31]) hh = '0;
      if (hh > HUM_LIMIT) hh = HUM_LIMIT;
      r.humidity_q10 = hh[28:12];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH beat %0d %s: got %h want %h", beats_checked, what, got, want);
      error_count++;
   endtask

   // Result checker and receiver stalls
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected beat", 32'd0, 32'd0);
            end else begin
               e = expected_q.pop_front();
               if (rsp_data.temperature_centi !== e.temperature_centi)
                  report_mismatch("temperature_centi", 32'(rsp_data.temperature_centi),
                                  32'(e.temperature_centi));
               if (rsp_data.pressure_pa !== e.pressure_pa)
                  report_mismatch("pressure_pa", rsp_data.pressure_pa, e.pressure_pa);
               if (rsp_data.pressure_valid !== e.pressure_valid)
                  report_mismatch("pressure_valid", 32'(rsp_data.pressure_valid),
                                  32'(e.pressure_valid));
               if (rsp_data.humidity_q10 !== e.humidity_q10)
                  report_mismatch("humidity_q10", 32'(rsp_data.humidity_q10),
                                  32'(e.humidity_q10));
            end
            beats_checked++;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else if (++idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("tb_sensor_raw_compensation: errors");
         $finish;
      end
   end

   // Valid drops only when the sender idles, so back-to-back beats keep it high
   task automatic send_beat(req_type s);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(compensate(s));
      beats_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write, only with the pipeline empty
   task automatic write_csr(csr_idx_type idx, logic [63:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TEMP:       temp_coef     = v[47:0];
         CSR_PRESS_LOW:  press_lo_coef = v;
         CSR_PRESS_HIGH: press_hi_coef = v;
         CSR_MIXED:      mixed_coef    = v[47:0];
         CSR_HUM:        hum_coef      = v[39:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Typical factory coefficients
   task automatic load_typical();
      write_csr(CSR_TEMP,       {16'd50, 16'd26435, 16'd27504});
      write_csr(CSR_PRESS_LOW,  {16'd2855, -16'sd10685, 16'd3024, 16'd36477});
      write_csr(CSR_PRESS_HIGH, {16'd3024, 16'd15500, -16'sd7, 16'd140});
      write_csr(CSR_MIXED,      {8'd0, 16'd364, 8'd75, 16'd6000});
      write_csr(CSR_HUM,        {8'd30, 16'd50, 16'd312});
   endtask

   task automatic load_random();
      write_csr(CSR_TEMP,       {$urandom, $urandom});
      write_csr(CSR_PRESS_LOW,  {$urandom, $urandom});
      write_csr(CSR_PRESS_HIGH, {$urandom, $urandom});
      write_csr(CSR_MIXED,      {$urandom, $urandom});
      write_csr(CSR_HUM,        {$urandom, $urandom});
   endtask

   function automatic req_type random_sample(bit realistic);
      req_type s;
      s.raw_temperature = realistic ? 20'(32'd480000 + $urandom_range(100000)) : 20'($urandom);
      s.raw_pressure    = realistic ? 20'(32'd300000 + $urandom_range(150000)) : 20'($urandom);
      s.raw_humidity    = 16'($urandom);
      return s;
   endfunction

   // Field extremes and a random sample under reset-value (zero) coefficients: divisor is zero
   task automatic test_zero_divisor();
      send_beat('0);
      send_beat('1);
      send_beat(random_sample(0));
      wait_drained();
   endtask

   // Field extremes and typical points with realistic, then extreme coefficients
   task automatic test_directed();
      load_typical();
      send_beat('0);
      send_beat('1);
      send_beat({20'd519888, 20'd415148, 16'd30000});
      send_beat({20'hFFFFF, 20'd0, 16'd0});
      send_beat({20'd0, 20'hFFFFF, 16'hFFFF});
      send_beat({20'h80000, 20'h80000, 16'h8000});
      wait_drained();
      // extreme coefficients: all ones, then sign bits, unsigned fields all ones
      write_csr(CSR_TEMP, '1); write_csr(CSR_PRESS_LOW, '1);
      write_csr(CSR_PRESS_HIGH, '1); write_csr(CSR_MIXED, '1); write_csr(CSR_HUM, '1);
      send_beat('0); send_beat('1); send_beat({20'd519888, 20'd415148, 16'd30000});
      wait_drained();
      write_csr(CSR_TEMP, 64'h8000_8000_FFFF); write_csr(CSR_PRESS_LOW, 64'h8000_8000_8000_FFFF);
      write_csr(CSR_PRESS_HIGH, 64'h8000_8000_8000_8000);
      write_csr(CSR_MIXED, 64'hFF80_00FF_8000); write_csr(CSR_HUM, 64'h80_8000_8000);
      send_beat('0); send_beat('1); send_beat(random_sample(1));
      wait_drained();
   endtask

   // One random phase under the given idle percentages
   task automatic test_random_phase(int send_pct, int recv_pct, int n, bit rand_coef);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      if (rand_coef) load_random(); else load_typical();
      for (int i = 0; i < n; i++) begin
         send_beat(random_sample($urandom_range(3) != 0));
         // sender holds off once until the pipeline is empty
         if (i == n / 2) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      temp_coef = '0; press_lo_coef = '0; press_hi_coef = '0;
      mixed_coef = '0; hum_coef = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_divisor();
      test_directed();
      test_random_phase(0, 0, 175, 0);
      test_random_phase(81, 0, 175, 1);
      test_random_phase(0, 81, 175, 0);
      test_random_phase(15, 15, 175, 1);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d sample sets, %0d results checked, under zero, typical,",
               beats_sent, beats_checked);
      $display("extreme and random coefficients with sender and receiver idling");
      if (error_count == 0 && expected_q.size() == 0)
         $display("tb_sensor_raw_compensation: clean");
      else
         $display("tb_sensor_raw_compensation: errors");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+sv
sv/src_pkg.sv
sv/src_tfine.sv
sv/src_hum.sv
sv/src_div.sv
sv/src_press.sv
sv/sensor_raw_compensation.sv
sv/src_chk.sv
tb/tb_sensor_raw_compensation.sv
